/* rtl/pae_pkg.sv */
// Shared types and constants for the particle advection step.
// No dependencies; imported by the configuration interface, the register file, both pipelines and the top level.
`default_nettype none

package pae_pkg;

  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 32;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP      = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WORLD_WIDTH    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CEILING_HEIGHT = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WALL_DAMPING   = 8'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OBSTACLE_LEFT  = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OBSTACLE_RIGHT = 8'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OBSTACLE_TOP   = 8'd6;
  localparam logic [CFG_IDX_W-1:0] REG_VELOCITY_CAP   = 8'd7;

  // Reset values.
  localparam logic [23:0] RST_TIME_STEP      = 24'd3355;
  localparam logic [30:0] RST_WORLD_WIDTH    = 31'd2684355;
  localparam logic [30:0] RST_CEILING_HEIGHT = 31'd1363149;
  localparam logic [16:0] RST_WALL_DAMPING   = 17'd0;
  localparam logic [30:0] RST_OBSTACLE_LEFT  = 31'd838861;
  localparam logic [30:0] RST_OBSTACLE_RIGHT = 31'd1363149;
  localparam logic [30:0] RST_OBSTACLE_TOP   = 31'd209715;
  localparam logic [30:0] RST_VELOCITY_CAP   = 31'd5242880;

  // 0.0001 in Q12.20, kept between a wall and a clamped particle.
  localparam logic [31:0] EDGE_MARGIN = 32'd105;

  // Product widths: 32 x 25 for the time step, 32 x 18 for the damping factor.
  localparam int unsigned DT_PROD_W   = 57;
  localparam int unsigned DAMP_PROD_W = 50;

  typedef struct packed {
    logic [23:0] time_step;
    logic [30:0] world_width;
    logic [30:0] ceiling_height;
    logic [16:0] wall_damping;
    logic [30:0] obstacle_left;
    logic [30:0] obstacle_right;
    logic [30:0] obstacle_top;
    logic [30:0] velocity_cap;
  } pae_cfg_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] acc_x;
    logic signed [31:0] acc_y;
    logic signed [31:0] smooth_vel_x;
    logic signed [31:0] smooth_vel_y;
    logic               last_in;
  } pae_item_t;

  // Integrated particle, before the walls and the obstacle are applied.
  typedef struct packed {
    logic               valid;
    logic signed [31:0] px0;
    logic signed [31:0] py0;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vy_damp;
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic               last;
  } pae_kin_t;

  typedef struct packed {
    logic               valid;
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic signed [31:0] new_smooth_x;
    logic signed [31:0] new_smooth_y;
    logic               last_out;
  } pae_result_t;

endpackage

`default_nettype wire

/* rtl/pae_in_if.sv */
// Request channel carrying one particle into the block.
// Depends on nothing but the package-free field widths of a particle.
`default_nettype none

interface pae_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [31:0] acc_x;
  logic signed [31:0] acc_y;
  logic signed [31:0] smooth_vel_x;
  logic signed [31:0] smooth_vel_y;
  logic               last_in;

  modport source (output valid, pos_x, pos_y, vel_x, vel_y, acc_x, acc_y,
                  smooth_vel_x, smooth_vel_y, last_in, input ready);
  modport sink   (input valid, pos_x, pos_y, vel_x, vel_y, acc_x, acc_y,
                  smooth_vel_x, smooth_vel_y, last_in, output ready);
endinterface

`default_nettype wire

/* rtl/pae_out_if.sv */
// Request channel carrying one updated particle out of the block.
// Stands alone; the widths follow the Q12.20 particle format.
`default_nettype none

interface pae_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] new_pos_x;
  logic signed [31:0] new_pos_y;
  logic signed [31:0] new_vel_x;
  logic signed [31:0] new_vel_y;
  logic signed [31:0] new_smooth_x;
  logic signed [31:0] new_smooth_y;
  logic               last_out;

  modport source (output valid, new_pos_x, new_pos_y, new_vel_x, new_vel_y,
                  new_smooth_x, new_smooth_y, last_out, input ready);
  modport sink   (input valid, new_pos_x, new_pos_y, new_vel_x, new_vel_y,
                  new_smooth_x, new_smooth_y, last_out, output ready);
endinterface

`default_nettype wire

/* rtl/pae_cfg_if.sv */
// Configuration write channel: register index and write data.
// Widths come from pae_pkg.
`default_nettype none

interface pae_cfg_if;
  import pae_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/pae_cfg_regs.sv */
// Configuration register file of the particle advection step.
// Depends on pae_pkg for the register indexes, reset values and pae_cfg_t.
`default_nettype none

module pae_cfg_regs
  import pae_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  wr_en,
  input  wire logic [CFG_IDX_W-1:0]  wr_index,
  input  wire logic [CFG_DATA_W-1:0] wr_data,
  output pae_cfg_t                   cfg
);

  pae_cfg_t cfg_r;
  pae_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        REG_TIME_STEP:      cfg_nxt.time_step      = wr_data[23:0];
        REG_WORLD_WIDTH:    cfg_nxt.world_width    = wr_data[30:0];
        REG_CEILING_HEIGHT: cfg_nxt.ceiling_height = wr_data[30:0];
        REG_WALL_DAMPING:   cfg_nxt.wall_damping   = wr_data[16:0];
        REG_OBSTACLE_LEFT:  cfg_nxt.obstacle_left  = wr_data[30:0];
        REG_OBSTACLE_RIGHT: cfg_nxt.obstacle_right = wr_data[30:0];
        REG_OBSTACLE_TOP:   cfg_nxt.obstacle_top   = wr_data[30:0];
        REG_VELOCITY_CAP:   cfg_nxt.velocity_cap   = wr_data[30:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.time_step      <= RST_TIME_STEP;
      cfg_r.world_width    <= RST_WORLD_WIDTH;
      cfg_r.ceiling_height <= RST_CEILING_HEIGHT;
      cfg_r.wall_damping   <= RST_WALL_DAMPING;
      cfg_r.obstacle_left  <= RST_OBSTACLE_LEFT;
      cfg_r.obstacle_right <= RST_OBSTACLE_RIGHT;
      cfg_r.obstacle_top   <= RST_OBSTACLE_TOP;
      cfg_r.velocity_cap   <= RST_VELOCITY_CAP;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

/* rtl/pae_kinematics.sv */
// Four-stage integration pipeline: velocity and position update by the
// time step, plus the first wall damping product. Depends on pae_pkg.
`default_nettype none

module pae_kinematics
  import pae_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      en,
  input  wire logic      in_valid,
  input  wire pae_item_t item,
  input  wire pae_cfg_t  cfg,
  output pae_kin_t       kin
);

  logic signed [24:0] dt_s;
  logic signed [17:0] wd_s;

  assign dt_s = $signed({1'b0, cfg.time_step});
  assign wd_s = $signed({1'b0, cfg.wall_damping});

  // Stage 1: acceleration times time step.
  logic                         s1_valid_r;
  pae_item_t                    s1_item_r;
  logic signed [DT_PROD_W-1:0]  s1_pax_r;
  logic signed [DT_PROD_W-1:0]  s1_pay_r;

  // Stage 2: new velocity.
  logic                         s2_valid_r;
  pae_item_t                    s2_item_r;
  pae_item_t                    s2_item_nxt;
  logic signed [31:0]           s2_vx_nxt;
  logic signed [31:0]           s2_vy_nxt;

  // Stage 3: velocity times time step, vertical velocity times damping.
  logic                         s3_valid_r;
  pae_item_t                    s3_item_r;
  logic signed [DT_PROD_W-1:0]  s3_pvx_r;
  logic signed [DT_PROD_W-1:0]  s3_pvy_r;
  logic signed [DAMP_PROD_W-1:0] s3_pd_r;

  // Stage 4: new position.
  pae_kin_t                     kin_r;
  pae_kin_t                     kin_nxt;

  // Taking bits [55:24] of the product is the floor shift, wrapped to 32 bits.
  assign s2_vx_nxt = s1_item_r.vel_x + s1_pax_r[55:24];
  assign s2_vy_nxt = s1_item_r.vel_y + s1_pay_r[55:24];

  always_comb begin
    s2_item_nxt       = s1_item_r;
    s2_item_nxt.vel_x = s2_vx_nxt;
    s2_item_nxt.vel_y = s2_vy_nxt;
  end

  always_comb begin
    kin_nxt         = kin_r;
    kin_nxt.valid   = s3_valid_r;
    kin_nxt.px0     = s3_item_r.pos_x;
    kin_nxt.py0     = s3_item_r.pos_y;
    kin_nxt.px      = s3_item_r.pos_x + s3_pvx_r[55:24];
    kin_nxt.py      = s3_item_r.pos_y + s3_pvy_r[55:24];
    kin_nxt.vx      = s3_item_r.vel_x;
    kin_nxt.vy      = s3_item_r.vel_y;
    kin_nxt.vy_damp = s3_pd_r[47:16];
    kin_nxt.sx      = s3_item_r.smooth_vel_x;
    kin_nxt.sy      = s3_item_r.smooth_vel_y;
    kin_nxt.last    = s3_item_r.last_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      kin_r.valid <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_valid;
      s1_item_r  <= item;
      s1_pax_r   <= DT_PROD_W'(item.acc_x) * DT_PROD_W'(dt_s);
      s1_pay_r   <= DT_PROD_W'(item.acc_y) * DT_PROD_W'(dt_s);

      s2_valid_r <= s1_valid_r;
      s2_item_r  <= s2_item_nxt;

      s3_valid_r <= s2_valid_r;
      s3_item_r  <= s2_item_r;
      s3_pvx_r   <= DT_PROD_W'(s2_item_r.vel_x) * DT_PROD_W'(dt_s);
      s3_pvy_r   <= DT_PROD_W'(s2_item_r.vel_y) * DT_PROD_W'(dt_s);
      s3_pd_r    <= DAMP_PROD_W'(s2_item_r.vel_y) * DAMP_PROD_W'(wd_s);

      kin_r      <= kin_nxt;
    end
  end

  assign kin = kin_r;

endmodule

`default_nettype wire

/* rtl/pae_bounds.sv */
// Three-stage boundary pipeline: edge wrap, floor and ceiling, obstacle
// freeze and velocity smoothing. Depends on pae_pkg.
`default_nettype none

module pae_bounds
  import pae_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     en,
  input  wire pae_kin_t kin,
  input  wire pae_cfg_t cfg,
  output pae_result_t   res
);

  logic signed [17:0] wd_s;
  logic signed [32:0] ww_e;
  logic signed [32:0] ch_e;
  logic signed [32:0] cap_e;

  assign wd_s  = $signed({1'b0, cfg.wall_damping});
  assign ww_e  = $signed({2'b00, cfg.world_width});
  assign ch_e  = $signed({2'b00, cfg.ceiling_height});
  assign cap_e = $signed({2'b00, cfg.velocity_cap});

  // Stage 5: walls.
  logic                          s5_valid_r;
  logic signed [31:0]            s5_px0_r, s5_py0_r, s5_px_r, s5_py_r;
  logic signed [31:0]            s5_vx_r, s5_vy_r, s5_d1_r, s5_sx_r, s5_sy_r;
  logic signed [DAMP_PROD_W-1:0] s5_pd2_r;
  logic                          s5_floor_r, s5_ceil_r, s5_last_r;

  logic signed [31:0] px_nxt, py_nxt, vx_nxt, pxl, pyf;
  logic               xhit, floor_hit, ceil_hit;

  always_comb begin
    pxl       = kin.px[31] ? (32'({1'b0, cfg.world_width}) - EDGE_MARGIN) : kin.px;
    xhit      = $signed({pxl[31], pxl}) >= ww_e;
    floor_hit = kin.py[31];
    pyf       = floor_hit ? 32'sd0 : kin.py;
    ceil_hit  = $signed({pyf[31], pyf}) >= ch_e;
    px_nxt    = xhit ? 32'sd0 : pxl;
    py_nxt    = ceil_hit ? $signed(32'({1'b0, cfg.ceiling_height}) - EDGE_MARGIN) : pyf;
    if ((xhit || ceil_hit) && ($signed({kin.vx[31], kin.vx}) > cap_e)) begin
      vx_nxt = $signed({1'b0, cfg.velocity_cap});
    end else begin
      vx_nxt = kin.vx;
    end
  end

  // Stage 6: damped velocity selection and obstacle freeze.
  logic               s6_valid_r;
  logic signed [31:0] s6_px_r, s6_py_r, s6_vx_r, s6_vy_r, s6_sx_r, s6_sy_r;
  logic               s6_last_r;

  logic signed [31:0] vy_b, px6_nxt, py6_nxt, vx6_nxt, vy6_nxt;
  logic               obst;

  always_comb begin
    if (s5_floor_r && s5_ceil_r) begin
      vy_b = s5_pd2_r[47:16];
    end else if (s5_floor_r || s5_ceil_r) begin
      vy_b = s5_d1_r;
    end else begin
      vy_b = s5_vy_r;
    end
    obst = !s5_py_r[31]
           && ($signed({1'b0, s5_py_r}) <= $signed({2'b00, cfg.obstacle_top}))
           && ($signed({s5_px_r[31], s5_px_r}) >= $signed({2'b00, cfg.obstacle_left}))
           && ($signed({s5_px_r[31], s5_px_r}) <= $signed({2'b00, cfg.obstacle_right}));
    px6_nxt = obst ? s5_px0_r : s5_px_r;
    py6_nxt = obst ? s5_py0_r : s5_py_r;
    vx6_nxt = obst ? 32'sd0 : s5_vx_r;
    vy6_nxt = obst ? 32'sd0 : vy_b;
  end

  // Stage 7: smoothed velocity is the floored mean of old smoothed and new.
  pae_result_t        res_r;
  logic signed [32:0] sumx, sumy;

  assign sumx = $signed({s6_sx_r[31], s6_sx_r}) + $signed({s6_vx_r[31], s6_vx_r});
  assign sumy = $signed({s6_sy_r[31], s6_sy_r}) + $signed({s6_vy_r[31], s6_vy_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_valid_r  <= 1'b0;
      s6_valid_r  <= 1'b0;
      res_r.valid <= 1'b0;
    end else if (en) begin
      s5_valid_r <= kin.valid;
      s5_px0_r   <= kin.px0;
      s5_py0_r   <= kin.py0;
      s5_px_r    <= px_nxt;
      s5_py_r    <= py_nxt;
      s5_vx_r    <= vx_nxt;
      s5_vy_r    <= kin.vy;
      s5_d1_r    <= kin.vy_damp;
      s5_pd2_r   <= DAMP_PROD_W'(kin.vy_damp) * DAMP_PROD_W'(wd_s);
      s5_floor_r <= floor_hit;
      s5_ceil_r  <= ceil_hit;
      s5_sx_r    <= kin.sx;
      s5_sy_r    <= kin.sy;
      s5_last_r  <= kin.last;

      s6_valid_r <= s5_valid_r;
      s6_px_r    <= px6_nxt;
      s6_py_r    <= py6_nxt;
      s6_vx_r    <= vx6_nxt;
      s6_vy_r    <= vy6_nxt;
      s6_sx_r    <= s5_sx_r;
      s6_sy_r    <= s5_sy_r;
      s6_last_r  <= s5_last_r;

      res_r.valid        <= s6_valid_r;
      res_r.new_pos_x    <= s6_px_r;
      res_r.new_pos_y    <= s6_py_r;
      res_r.new_vel_x    <= s6_vx_r;
      res_r.new_vel_y    <= s6_vy_r;
      res_r.new_smooth_x <= sumx[32:1];
      res_r.new_smooth_y <= sumy[32:1];
      res_r.last_out     <= s6_last_r;
    end
  end

  assign res = res_r;

endmodule

`default_nettype wire

/* rtl/particle_advection_step.sv */
// Top level of the particle advection step: configuration registers, the
// integration pipeline and the boundary pipeline. Depends on pae_pkg,
// pae_in_if, pae_out_if, pae_cfg_if, pae_cfg_regs, pae_kinematics, pae_bounds.
`default_nettype none

// The block advances one particle by one semi-implicit Euler step and takes
// a new particle request in every cycle while the output is not held back.
// A particle passes seven register stages, and the sustained rate is one
// particle per cycle when the output side keeps up. The whole pipeline moves
// together: while the result in the output register is held back, every
// stage holds and no new request is accepted, and nothing is lost or
// repeated. The stages are: acceleration times time step, velocity add,
// velocity times time step together with the first wall damping product,
// position add, edge wrap and wall tests together with the second damping
// product (a particle that touches both floor and ceiling is damped twice),
// obstacle freeze, and the smoothed velocity mean into the output register.
// The configuration port is always ready and takes effect at once; it must
// only be written while no particle is in flight. Writes to an index past the
// last register are ignored.

module particle_advection_step
  import pae_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  pae_in_if.sink    in_ch,
  pae_out_if.source out_ch,
  pae_cfg_if.sink   cfg_ch
);

  pae_cfg_t    cfg;
  pae_item_t   item;
  pae_kin_t    kin;
  pae_result_t res;
  logic        en;

  // The pipeline advances whenever the output register is empty or drained.
  assign en           = !res.valid || out_ch.ready;
  assign in_ch.ready  = en;
  assign cfg_ch.ready = 1'b1;

  assign item.pos_x        = in_ch.pos_x;
  assign item.pos_y        = in_ch.pos_y;
  assign item.vel_x        = in_ch.vel_x;
  assign item.vel_y        = in_ch.vel_y;
  assign item.acc_x        = in_ch.acc_x;
  assign item.acc_y        = in_ch.acc_y;
  assign item.smooth_vel_x = in_ch.smooth_vel_x;
  assign item.smooth_vel_y = in_ch.smooth_vel_y;
  assign item.last_in      = in_ch.last_in;

  pae_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_ch.valid),
    .wr_index (cfg_ch.index),
    .wr_data  (cfg_ch.data),
    .cfg      (cfg)
  );

  pae_kinematics u_kin (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_ch.valid),
    .item     (item),
    .cfg      (cfg),
    .kin      (kin)
  );

  pae_bounds u_bounds (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .kin   (kin),
    .cfg   (cfg),
    .res   (res)
  );

  assign out_ch.valid        = res.valid;
  assign out_ch.new_pos_x    = res.new_pos_x;
  assign out_ch.new_pos_y    = res.new_pos_y;
  assign out_ch.new_vel_x    = res.new_vel_x;
  assign out_ch.new_vel_y    = res.new_vel_y;
  assign out_ch.new_smooth_x = res.new_smooth_x;
  assign out_ch.new_smooth_y = res.new_smooth_y;
  assign out_ch.last_out     = res.last_out;

endmodule

`default_nettype wire
